FILE: hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and sequencer state type for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_BYTES   = 4;
  localparam int unsigned KSEL_W      = $clog2(KEY_BYTES);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KEY_W       = KEY_BYTES * BYTE_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_FILL     = 12'b0000_0000_0010,
    ST_KS_RD_I  = 12'b0000_0000_0100,
    ST_KS_RD_J  = 12'b0000_0000_1000,
    ST_KS_WR_I  = 12'b0000_0001_0000,
    ST_KS_WR_J  = 12'b0000_0010_0000,
    ST_PG_RD_I  = 12'b0000_0100_0000,
    ST_PG_RD_J  = 12'b0000_1000_0000,
    ST_PG_WR_I  = 12'b0001_0000_0000,
    ST_PG_WR_J  = 12'b0010_0000_0000,
    ST_PG_RD_K  = 12'b0100_0000_0000,
    ST_PG_OUT   = 12'b1000_0000_0000
  } state_t;

endpackage

FILE: hdl/rc4_stream_cipher_4byte_key_top.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_4byte_key_top
// RC4 byte cipher with a 4-byte key; one shared dual-port permutation RAM
// driven by a small sequencer for key scheduling and keystream generation.
// ----------------------------------------------------------------------------
// A byte steps through PG_RD_I, PG_RD_J, PG_WR_I, PG_WR_J, PG_RD_K, then PG_OUT, where
// out_valid is set once the output register is free. A message start (or the first
// byte after reset) first schedules the key: identity fill of all 256 entries, then a
// swap per entry. in_ready is low until the sequencer is idle (single RAM read port).
// Reset: synchronous active-low; clears control, indices, key and keyed flag.
// The RAM is not cleared; the first byte after reset always schedules it.
module rc4_stream_cipher_4byte_key_top
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [KEY_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_start_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_cipher_byte
);

  logic [BYTE_W-1:0] perm_mem [TABLE_DEPTH];

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  ctr_r, ctr_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [BYTE_W-1:0] si_r, si_nxt;
  logic [IDX_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              keyed_r, keyed_nxt;
  logic [KEY_W-1:0]  key_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] key_byte;
  logic              in_acc;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

  assign key_byte = key_r[ctr_r[KSEL_W-1:0]*BYTE_W +: BYTE_W];

  // permutation RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= perm_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sum_nxt       = sum_r;
    data_nxt      = data_r;
    keyed_nxt     = keyed_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    wr_en         = 1'b0;
    wr_addr       = ctr_r;
    wr_data       = ctr_r;
    rd_addr       = sum_r;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt = in_data_byte;
          if (in_start_of_message || !keyed_r) begin
            ctr_nxt   = '0;
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_PG_RD_I;
          end
        end
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == IDX_LAST) begin
          j_nxt     = '0;
          state_nxt = ST_KS_RD_I;
        end
      end
      ST_KS_RD_I: begin
        rd_addr   = ctr_r;
        state_nxt = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        si_nxt    = rd_data_r;
        j_nxt     = j_r + rd_data_r + key_byte;
        rd_addr   = j_nxt;
        state_nxt = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        wr_en     = 1'b1;
        wr_addr   = ctr_r;
        wr_data   = rd_data_r;
        state_nxt = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = si_r;
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == IDX_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
          state_nxt = ST_PG_RD_I;
        end else begin
          state_nxt = ST_KS_RD_I;
        end
      end
      ST_PG_RD_I: begin
        i_nxt     = i_r + 1'b1;
        rd_addr   = i_nxt;
        state_nxt = ST_PG_RD_J;
      end
      ST_PG_RD_J: begin
        si_nxt    = rd_data_r;
        j_nxt     = j_r + rd_data_r;
        rd_addr   = j_nxt;
        state_nxt = ST_PG_WR_I;
      end
      ST_PG_WR_I: begin
        wr_en     = 1'b1;
        wr_addr   = i_r;
        wr_data   = rd_data_r;
        sum_nxt   = si_r + rd_data_r;
        state_nxt = ST_PG_WR_J;
      end
      ST_PG_WR_J: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = si_r;
        state_nxt = ST_PG_RD_K;
      end
      ST_PG_RD_K: begin
        state_nxt = ST_PG_OUT;
      end
      ST_PG_OUT: begin
        // hold until the output register is free; rd_addr stays on sum_r
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ rd_data_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        key_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sum_r      <= sum_nxt;
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // a message start always triggers a fresh schedule
  a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_start_of_message) |=> (state_r == ST_FILL))
    else $error("start of message did not start key scheduling");

  // an unkeyed table is never used for keystream
  a_unkeyed_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !keyed_r) |=> (state_r == ST_FILL))
    else $error("item accepted on unkeyed table without scheduling");

  // once keyed, stays keyed until reset
  a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    keyed_r |=> keyed_r)
    else $error("keyed flag dropped");

  // schedule end restarts both indices at zero
  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KS_WR_J && ctr_r == IDX_LAST)
      |=> (state_r == ST_PG_RD_I && i_r == '0 && j_r == '0 && keyed_r))
    else $error("indices not reset at end of key scheduling");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PG_OUT && out_valid_r && !out_ready) |=> (state_r == ST_PG_OUT))
    else $error("result overwrote a pending item");

endmodule
